### rtl/see_pkg.sv
// shared types, constants and codes of the sprite evaluation engine
`default_nettype none

package see_pkg;

    // primary sprite memory geometry
    localparam int OAM_DEPTH       = 256;
    localparam int PRIMARY_SPRITES = 64;

    // default number of slots in the line list, four bytes per slot
    localparam int LINE_SLOTS_DEF = 8;
    localparam int SLOT_BYTES     = 4;

    // command queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // scanline at which evaluation stops
    localparam logic signed [9:0] EVAL_END_LINE = 10'sd240;
    localparam logic signed [9:0] PRE_RENDER    = -10'sd1;

    // dot schedule
    localparam logic [8:0] DOT_CLEAR_END = 9'd64;
    localparam logic [8:0] DOT_EVAL_END  = 9'd256;
    localparam logic [8:0] DOT_ADDR_END  = 9'd320;
    localparam logic [8:0] DOT_EMIT      = 9'd321;

    // list fill byte
    localparam logic [7:0] LIST_FILL = 8'hFF;

    // input opcodes
    localparam logic [1:0] OP_ADDR_WR = 2'd0;
    localparam logic [1:0] OP_DATA_WR = 2'd1;
    localparam logic [1:0] OP_TICK    = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_SPRITE_SIZE  = 2'd0;
    localparam logic [1:0] CFG_SPRITE_TABLE = 2'd1;
    localparam logic [1:0] CFG_RENDER_EN    = 2'd2;

    // work classes handed from front to back
    typedef enum logic [2:0] {
        CMD_ADDR_WR,
        CMD_DATA_WR,
        CMD_ITER_RESET,
        CMD_LIST_CLEAR,
        CMD_OAM_READ,
        CMD_EVAL,
        CMD_ADDR_CLEAR,
        CMD_EMIT
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t         kind;
        logic              clr_ovf;
        logic [7:0]        data;
        logic signed [9:0] line;
    } cmd_t;

    typedef struct packed {
        logic sprite_size;
        logic sprite_table;
        logic rendering_enabled;
    } cfg_t;

    typedef enum logic [1:0] {
        BK_CLEAR,
        BK_RUN,
        BK_EMIT_RD,
        BK_EMIT_OUT
    } back_state_t;

endpackage

`default_nettype wire

### rtl/see_cmd_queue.sv
// short command queue between the classifying front and the executing back
`default_nettype none

module see_cmd_queue (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        push,
    input  wire see_pkg::cmd_t push_cmd,
    input  wire logic        pop,
    output see_pkg::cmd_t    head,
    output logic             full,
    output logic             not_empty
);

    see_pkg::cmd_t                 store [see_pkg::QUEUE_DEPTH];
    logic [see_pkg::QPTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [see_pkg::QPTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [see_pkg::QPTR_W:0]      count_reg, count_next;

    // pointer and fill count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (!push && pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        if (push) begin
            store[wr_ptr_reg] <= push_cmd;
        end
    end

    assign head      = store[rd_ptr_reg];
    assign full      = (count_reg == (see_pkg::QPTR_W+1)'(see_pkg::QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);

endmodule

`default_nettype wire

### rtl/see_front.sv
// input handshake and classification of host writes and dot ticks
`default_nettype none

module see_front (
    input  wire logic              accept_en,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic [1:0]        s_opcode,
    input  wire logic [7:0]        s_data,
    input  wire logic signed [9:0] s_scanline,
    input  wire logic [8:0]        s_dot,
    input  wire logic              q_full,
    output logic                   push,
    output see_pkg::cmd_t          push_cmd
);

    logic       keep;
    logic [8:0] dot_m1;

    assign dot_m1 = s_dot - 9'd1;

    // sort the item into a back-end work class, drop items that do nothing
    always_comb begin
        keep             = 1'b1;
        push_cmd.kind    = see_pkg::CMD_ADDR_WR;
        push_cmd.clr_ovf = 1'b0;
        push_cmd.data    = s_data;
        push_cmd.line    = s_scanline;
        case (s_opcode)
            see_pkg::OP_ADDR_WR: begin
                push_cmd.kind = see_pkg::CMD_ADDR_WR;
            end
            see_pkg::OP_DATA_WR: begin
                push_cmd.kind = see_pkg::CMD_DATA_WR;
            end
            see_pkg::OP_TICK: begin
                push_cmd.clr_ovf = (s_scanline == see_pkg::PRE_RENDER) && (s_dot == 9'd1);
                if (s_scanline >= see_pkg::EVAL_END_LINE) begin
                    keep = 1'b0;
                end else if (s_dot == 9'd0) begin
                    push_cmd.kind = see_pkg::CMD_ITER_RESET;
                end else if (s_dot <= see_pkg::DOT_CLEAR_END) begin
                    // list byte cleared on this dot
                    push_cmd.kind = see_pkg::CMD_LIST_CLEAR;
                    push_cmd.data = {3'b000, dot_m1[5:1]};
                end else if (s_dot <= see_pkg::DOT_EVAL_END) begin
                    push_cmd.kind = s_dot[0] ? see_pkg::CMD_OAM_READ : see_pkg::CMD_EVAL;
                end else if (s_dot <= see_pkg::DOT_ADDR_END) begin
                    push_cmd.kind = see_pkg::CMD_ADDR_CLEAR;
                end else if (s_dot == see_pkg::DOT_EMIT) begin
                    push_cmd.kind = see_pkg::CMD_EMIT;
                end else begin
                    keep = 1'b0;
                end
            end
            default: begin
                keep = 1'b0;
            end
        endcase
    end

    assign s_ready = accept_en && !q_full;
    assign push    = s_valid && s_ready && keep;

endmodule

`default_nettype wire

### rtl/see_back.sv
// execution of queued work: sprite memory, evaluation counters, line list, slot output
`default_nettype none

module see_back #(
    parameter int LINE_SLOTS = see_pkg::LINE_SLOTS_DEF
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire see_pkg::cfg_t cfg,
    input  wire logic          q_valid,
    input  wire see_pkg::cmd_t q_cmd,
    output logic               q_pop,
    output logic               clearing,
    output logic               m_valid,
    input  wire logic          m_ready,
    output logic               m_slot_valid,
    output logic [2:0]         m_slot_index,
    output logic [7:0]         m_sprite_y,
    output logic [7:0]         m_sprite_tile,
    output logic [7:0]         m_sprite_attr,
    output logic [7:0]         m_sprite_x,
    output logic [12:0]        m_pattern_addr,
    output logic               m_sprite_zero_present,
    output logic               m_overflow,
    output logic               m_last
);

    localparam int LIST_BYTES = LINE_SLOTS * see_pkg::SLOT_BYTES;
    localparam int SLOT_W     = (LINE_SLOTS > 1) ? $clog2(LINE_SLOTS) : 1;
    localparam int LANES      = see_pkg::SLOT_BYTES;

    see_pkg::back_state_t state_reg, state_next;

    logic [7:0]        clr_cnt_reg, clr_cnt_next;
    logic [7:0]        oam_addr_reg, oam_addr_next;
    logic [7:0]        read_buffer_reg;
    logic [7:0]        spr_cnt_reg, spr_cnt_next;
    logic [1:0]        byte_cnt_reg, byte_cnt_next;
    logic [7:0]        list_ptr_reg, list_ptr_next;
    logic              zero_now_reg, zero_now_next;
    logic              zero_line_reg, zero_line_next;
    logic              ovf_reg, ovf_next;
    logic [2:0]        slot_reg, slot_next;
    logic signed [9:0] emit_line_reg, emit_line_next;

    // sprite memory ports
    logic       mem_we;
    logic [7:0] mem_waddr;
    logic [7:0] mem_wdata;
    logic       mem_re;
    logic [7:0] mem_raddr;
    logic [7:0] oam_mem [see_pkg::OAM_DEPTH];

    // line list ports, one lane per byte of a slot
    logic              list_req;
    logic              list_we;
    logic [7:0]        list_waddr;
    logic [7:0]        list_wdata;
    logic              list_re;
    logic [SLOT_W-1:0] list_widx;
    logic [SLOT_W-1:0] list_ridx;
    logic [7:0]        list_mem [LANES][LINE_SLOTS];
    logic [LINE_SLOTS-1:0] list_vld_reg [LANES];
    logic [7:0]        lane_rd_reg [LANES];
    logic              lane_vld_rd_reg [LANES];
    logic [7:0]        lane_byte [LANES];

    // evaluation helpers
    logic signed [10:0] diff;
    logic               in_rng;
    logic               out_free;
    logic               out_load;
    logic               last_slot;

    // output register
    logic        m_valid_reg, m_valid_next;
    logic [2:0]  out_index_reg;
    logic [7:0]  out_y_reg, out_tile_reg, out_attr_reg, out_x_reg;
    logic [12:0] out_addr_reg;
    logic        out_zero_reg, out_ovf_reg, out_last_reg;

    // slot result built from the registered list read
    logic [7:0]  row;
    logic [7:0]  row_f;
    logic [12:0] pat_addr;

    // y range test of the buffered byte against the current line
    assign diff   = {q_cmd.line[9], q_cmd.line} - $signed({3'b000, read_buffer_reg});
    assign in_rng = !diff[10] && (diff[9:4] == 6'd0) && (cfg.sprite_size || !diff[3]);

    assign out_free  = !m_valid_reg || m_ready;
    assign last_slot = (slot_reg == 3'(LINE_SLOTS - 1));

    // control: next state, counters and memory requests
    always_comb begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        oam_addr_next  = oam_addr_reg;
        spr_cnt_next   = spr_cnt_reg;
        byte_cnt_next  = byte_cnt_reg;
        list_ptr_next  = list_ptr_reg;
        zero_now_next  = zero_now_reg;
        zero_line_next = zero_line_reg;
        ovf_next       = ovf_reg;
        slot_next      = slot_reg;
        emit_line_next = emit_line_reg;
        mem_we         = 1'b0;
        mem_waddr      = oam_addr_reg;
        mem_wdata      = q_cmd.data;
        mem_re         = 1'b0;
        mem_raddr      = {spr_cnt_reg[5:0], 2'b00} + {6'd0, byte_cnt_reg} + oam_addr_reg;
        list_req       = 1'b0;
        list_waddr     = list_ptr_reg;
        list_wdata     = read_buffer_reg;
        list_re        = 1'b0;
        q_pop          = 1'b0;
        out_load       = 1'b0;
        case (state_reg)
            see_pkg::BK_CLEAR: begin
                // zero the sprite memory one entry a cycle
                mem_we       = 1'b1;
                mem_waddr    = clr_cnt_reg;
                mem_wdata    = 8'd0;
                clr_cnt_next = clr_cnt_reg + 8'd1;
                if (clr_cnt_reg == 8'hFF) begin
                    state_next = see_pkg::BK_RUN;
                end
            end
            see_pkg::BK_RUN: begin
                if (q_valid) begin
                    q_pop = 1'b1;
                    if (q_cmd.clr_ovf) begin
                        ovf_next = 1'b0;
                    end
                    case (q_cmd.kind)
                        see_pkg::CMD_ADDR_WR: begin
                            oam_addr_next = q_cmd.data;
                        end
                        see_pkg::CMD_DATA_WR: begin
                            mem_we        = 1'b1;
                            oam_addr_next = oam_addr_reg + 8'd1;
                        end
                        see_pkg::CMD_ITER_RESET: begin
                            spr_cnt_next  = 8'd0;
                            byte_cnt_next = 2'd0;
                            zero_now_next = 1'b0;
                            list_ptr_next = 8'd0;
                        end
                        see_pkg::CMD_LIST_CLEAR: begin
                            list_req   = 1'b1;
                            list_waddr = q_cmd.data;
                            list_wdata = see_pkg::LIST_FILL;
                        end
                        see_pkg::CMD_OAM_READ: begin
                            mem_re = 1'b1;
                        end
                        see_pkg::CMD_EVAL: begin
                            if (list_ptr_reg[1:0] != 2'd0) begin
                                // copy the rest of an in-range sprite
                                list_req      = 1'b1;
                                list_ptr_next = list_ptr_reg + 8'd1;
                                byte_cnt_next = byte_cnt_reg + 2'd1;
                                if (byte_cnt_reg == 2'd3) begin
                                    spr_cnt_next = spr_cnt_reg + 8'd1;
                                end
                            end else if (spr_cnt_reg >= 8'(see_pkg::PRIMARY_SPRITES)) begin
                                // all sprites seen
                                list_req     = 1'b1;
                                spr_cnt_next = spr_cnt_reg + 8'd1;
                            end else if (list_ptr_reg >= 8'(LIST_BYTES)) begin
                                // list full: overflow check with the diagonal walk
                                byte_cnt_next = byte_cnt_reg + 2'd1;
                                if (in_rng) begin
                                    if (cfg.rendering_enabled) begin
                                        ovf_next = 1'b1;
                                    end
                                    list_ptr_next = list_ptr_reg + 8'd1;
                                end else begin
                                    spr_cnt_next = spr_cnt_reg + 8'd1;
                                end
                            end else begin
                                // y test, store y either way
                                list_req = 1'b1;
                                if (in_rng) begin
                                    if (spr_cnt_reg == 8'd0) begin
                                        zero_now_next = 1'b1;
                                    end
                                    list_ptr_next = list_ptr_reg + 8'd1;
                                    byte_cnt_next = byte_cnt_reg + 2'd1;
                                end else begin
                                    spr_cnt_next = spr_cnt_reg + 8'd1;
                                end
                            end
                        end
                        see_pkg::CMD_ADDR_CLEAR: begin
                            oam_addr_next = 8'd0;
                        end
                        see_pkg::CMD_EMIT: begin
                            state_next     = see_pkg::BK_EMIT_RD;
                            slot_next      = 3'd0;
                            emit_line_next = q_cmd.line;
                            zero_line_next = zero_now_reg;
                        end
                        default: begin
                            oam_addr_next = oam_addr_reg;
                        end
                    endcase
                end
            end
            see_pkg::BK_EMIT_RD: begin
                list_re    = 1'b1;
                state_next = see_pkg::BK_EMIT_OUT;
            end
            see_pkg::BK_EMIT_OUT: begin
                if (out_free) begin
                    out_load  = 1'b1;
                    slot_next = slot_reg + 3'd1;
                    state_next = last_slot ? see_pkg::BK_RUN : see_pkg::BK_EMIT_RD;
                end
            end
            default: begin
                state_next = see_pkg::BK_CLEAR;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= see_pkg::BK_CLEAR;
            clr_cnt_reg   <= 8'd0;
            oam_addr_reg  <= 8'd0;
            spr_cnt_reg   <= 8'd0;
            byte_cnt_reg  <= 2'd0;
            list_ptr_reg  <= 8'd0;
            zero_now_reg  <= 1'b0;
            zero_line_reg <= 1'b0;
            ovf_reg       <= 1'b0;
            slot_reg      <= 3'd0;
        end else begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            oam_addr_reg  <= oam_addr_next;
            spr_cnt_reg   <= spr_cnt_next;
            byte_cnt_reg  <= byte_cnt_next;
            list_ptr_reg  <= list_ptr_next;
            zero_now_reg  <= zero_now_next;
            zero_line_reg <= zero_line_next;
            ovf_reg       <= ovf_next;
            slot_reg      <= slot_next;
        end
    end

    always_ff @(posedge aclk) begin
        emit_line_reg <= emit_line_next;
    end

    assign clearing = (state_reg == see_pkg::BK_CLEAR);

    // sprite memory write port
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            oam_mem[mem_waddr] <= mem_wdata;
        end
    end

    // sprite memory read port, its output register is the read buffer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            read_buffer_reg <= 8'd0;
        end else if (mem_re) begin
            read_buffer_reg <= oam_mem[mem_raddr];
        end
    end

    // line list: writes beyond the list are dropped
    assign list_we   = list_req && (list_waddr < 8'(LIST_BYTES));
    assign list_widx = list_waddr[2 +: SLOT_W];
    assign list_ridx = slot_reg[SLOT_W-1:0];

    always_ff @(posedge aclk) begin
        if (list_we) begin
            list_mem[list_waddr[1:0]][list_widx] <= list_wdata;
        end
    end

    // written marks, an unwritten byte reads as the fill byte
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int b = 0; b < LANES; b++) begin
                list_vld_reg[b] <= '0;
            end
        end else if (list_we) begin
            list_vld_reg[list_waddr[1:0]][list_widx] <= 1'b1;
        end
    end

    // slot read, all four lanes at the same slot
    always_ff @(posedge aclk) begin
        if (list_re) begin
            for (int b = 0; b < LANES; b++) begin
                lane_rd_reg[b]     <= list_mem[b][list_ridx];
                lane_vld_rd_reg[b] <= list_vld_reg[b][list_ridx];
            end
        end
    end

    always_comb begin
        for (int b = 0; b < LANES; b++) begin
            lane_byte[b] = lane_vld_rd_reg[b] ? lane_rd_reg[b] : see_pkg::LIST_FILL;
        end
    end

    // pattern address with vertical flip
    always_comb begin
        row   = emit_line_reg[7:0] - lane_byte[0];
        row_f = row;
        if (lane_byte[2][7]) begin
            row_f = (cfg.sprite_size ? 8'd15 : 8'd7) - row;
        end
        if (cfg.sprite_size) begin
            pat_addr = {lane_byte[1][0], lane_byte[1][7:1], row_f[3], 1'b0, row_f[2:0]};
        end else begin
            pat_addr = {cfg.sprite_table, lane_byte[1], 1'b0, row_f[2:0]};
        end
    end

    // result register
    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_index_reg <= slot_reg;
            out_y_reg     <= lane_byte[0];
            out_tile_reg  <= lane_byte[1];
            out_attr_reg  <= lane_byte[2];
            out_x_reg     <= lane_byte[3];
            out_addr_reg  <= pat_addr;
            out_zero_reg  <= zero_line_reg;
            out_ovf_reg   <= ovf_reg;
            out_last_reg  <= last_slot;
        end
    end

    assign m_valid               = m_valid_reg;
    assign m_slot_valid          = 1'b1;
    assign m_slot_index          = out_index_reg;
    assign m_sprite_y            = out_y_reg;
    assign m_sprite_tile         = out_tile_reg;
    assign m_sprite_attr         = out_attr_reg;
    assign m_sprite_x            = out_x_reg;
    assign m_pattern_addr        = out_addr_reg;
    assign m_sprite_zero_present = out_zero_reg;
    assign m_overflow            = out_ovf_reg;
    assign m_last                = out_last_reg;

endmodule

`default_nettype wire

### rtl/sprite_evaluation_engine_unit.sv
// Sprite evaluation engine: host writes and dot ticks in, slot results out.
// Flow: each item is queued and then executed by the back end; the dot 321 tick starts
// the slot output, which reads each list slot and registers it once the result register is free.
// Throughput: one item per cycle while s_ready is high; s_ready is low while the queue
// is full, and the back end holds its queue while it emits slots (LINE_SLOTS results).
// Reset: synchronous, active low; afterwards the 256-entry sprite memory is zeroed one
// entry a cycle, and s_ready stays low until it is cleared.
`default_nettype none

module sprite_evaluation_engine_unit #(
    parameter int LINE_SLOTS = see_pkg::LINE_SLOTS_DEF
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    // configuration writes
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [1:0]        cfg_index,
    input  wire logic              cfg_data,
    // input items
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic [1:0]        s_opcode,
    input  wire logic [7:0]        s_data,
    input  wire logic signed [9:0] s_scanline,
    input  wire logic [8:0]        s_dot,
    // slot results
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic                   m_slot_valid,
    output logic [2:0]             m_slot_index,
    output logic [7:0]             m_sprite_y,
    output logic [7:0]             m_sprite_tile,
    output logic [7:0]             m_sprite_attr,
    output logic [7:0]             m_sprite_x,
    output logic [12:0]            m_pattern_addr,
    output logic                   m_sprite_zero_present,
    output logic                   m_overflow,
    output logic                   m_last
);

    see_pkg::cfg_t cfg_reg, cfg_next;
    see_pkg::cmd_t push_cmd;
    see_pkg::cmd_t q_head;
    logic          push;
    logic          q_full;
    logic          q_valid;
    logic          q_pop;
    logic          clearing;

    // configuration registers, taken on every transfer
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                see_pkg::CFG_SPRITE_SIZE:  cfg_next.sprite_size       = cfg_data;
                see_pkg::CFG_SPRITE_TABLE: cfg_next.sprite_table      = cfg_data;
                see_pkg::CFG_RENDER_EN:    cfg_next.rendering_enabled = cfg_data;
                default:                   cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg_ready = 1'b1;

    see_front u_front (
        .accept_en  (!clearing),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_opcode   (s_opcode),
        .s_data     (s_data),
        .s_scanline (s_scanline),
        .s_dot      (s_dot),
        .q_full     (q_full),
        .push       (push),
        .push_cmd   (push_cmd)
    );

    see_cmd_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_cmd  (push_cmd),
        .pop       (q_pop),
        .head      (q_head),
        .full      (q_full),
        .not_empty (q_valid)
    );

    see_back #(
        .LINE_SLOTS (LINE_SLOTS)
    ) u_back (
        .aclk                  (aclk),
        .aresetn               (aresetn),
        .cfg                   (cfg_reg),
        .q_valid               (q_valid),
        .q_cmd                 (q_head),
        .q_pop                 (q_pop),
        .clearing              (clearing),
        .m_valid               (m_valid),
        .m_ready               (m_ready),
        .m_slot_valid          (m_slot_valid),
        .m_slot_index          (m_slot_index),
        .m_sprite_y            (m_sprite_y),
        .m_sprite_tile         (m_sprite_tile),
        .m_sprite_attr         (m_sprite_attr),
        .m_sprite_x            (m_sprite_x),
        .m_pattern_addr        (m_pattern_addr),
        .m_sprite_zero_present (m_sprite_zero_present),
        .m_overflow            (m_overflow),
        .m_last                (m_last)
    );

endmodule

`default_nettype wire

### rtl/see_checker.sv
// port-level checker of the sprite evaluation engine and its bind
`default_nettype none

module see_checker #(
    parameter int LINE_SLOTS = see_pkg::LINE_SLOTS_DEF
) (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_valid,
    input wire logic        s_ready,
    input wire logic [1:0]  s_opcode,
    input wire logic [7:0]  s_data,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic        m_slot_valid,
    input wire logic [2:0]  m_slot_index,
    input wire logic [12:0] m_pattern_addr,
    input wire logic        m_last
);

    // a stalled input transfer keeps its item
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_opcode) && $stable(s_data))
        else $error("input item changed while stalled");

    // a stalled result keeps its value
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_slot_index) && $stable(m_pattern_addr))
        else $error("result changed while stalled");

    // the final result of a tick is the last slot of the list
    a_last_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_last |-> m_slot_valid && (m_slot_index == 3'(LINE_SLOTS - 1)))
        else $error("last marker on the wrong slot");

    // nothing is taken or shown right after reset while memory is cleared
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !s_ready && !m_valid)
        else $error("activity right after reset");

endmodule

bind sprite_evaluation_engine_unit see_checker #(
    .LINE_SLOTS (LINE_SLOTS)
) u_see_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_valid        (s_valid),
    .s_ready        (s_ready),
    .s_opcode       (s_opcode),
    .s_data         (s_data),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_slot_valid   (m_slot_valid),
    .m_slot_index   (m_slot_index),
    .m_pattern_addr (m_pattern_addr),
    .m_last         (m_last)
);

`default_nettype wire
